// ----- rtl/lpsd_pkg.sv -----
package lpsd_pkg;

    localparam int PANEL_WIDTH  = 64;
    localparam int PANEL_HEIGHT = 64;
    localparam int LINE_PAIRS   = PANEL_HEIGHT / 2;
    localparam int COL_W        = $clog2(PANEL_WIDTH);
    localparam int LINE_W       = $clog2(LINE_PAIRS);
    localparam int HALF_ADDR_W  = LINE_W + COL_W;
    localparam int HALF_DEPTH   = LINE_PAIRS * PANEL_WIDTH;

    localparam int COORD_W      = 6;
    localparam int LEVEL_W      = 8;
    localparam int ROW_ADDR_W   = 5;
    localparam int DWELL_W      = 16;
    localparam int RGB_W        = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_THRESHOLD = 8'd128;
    localparam logic [DWELL_W-1:0] DWELL_RESET     = 16'd100;

    localparam logic OP_PIXEL_WRITE = 1'b0;
    localparam logic OP_SCAN_TICK   = 1'b1;

    typedef struct packed {
        logic                  shift;
        logic                  latch;
        logic                  off;
        logic                  fend;
        logic [ROW_ADDR_W-1:0] row;
    } scan_event_t;

endpackage

// ----- rtl/lpsd_frame_store.sv -----
module lpsd_frame_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic                            wr_bottom,
    input  logic [lpsd_pkg::HALF_ADDR_W-1:0] wr_addr,
    input  logic [lpsd_pkg::RGB_W-1:0]       wr_data,
    input  logic                            rd_en,
    input  logic [lpsd_pkg::HALF_ADDR_W-1:0] rd_addr,
    output logic [lpsd_pkg::RGB_W-1:0]       top_rgb,
    output logic [lpsd_pkg::RGB_W-1:0]       bottom_rgb,
    output logic                            busy
);
    import lpsd_pkg::*;

    // Upper and lower halves of the panel live in separate arrays so that one
    // shift event reads both pixels of a column in the same cycle.
    logic [RGB_W-1:0] top_mem    [HALF_DEPTH];
    logic [RGB_W-1:0] bottom_mem [HALF_DEPTH];

    logic [HALF_ADDR_W-1:0] clr_addr_reg;
    logic [HALF_ADDR_W-1:0] clr_addr_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic [RGB_W-1:0]       top_rd_reg;
    logic [RGB_W-1:0]       bottom_rd_reg;

    logic                   top_we;
    logic                   bottom_we;
    logic [HALF_ADDR_W-1:0] mem_addr;
    logic [RGB_W-1:0]       mem_data;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == HALF_ADDR_W'(HALF_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    assign top_we    = busy_reg || (wr_en && !wr_bottom);
    assign bottom_we = busy_reg || (wr_en && wr_bottom);
    assign mem_addr  = busy_reg ? clr_addr_reg : wr_addr;
    assign mem_data  = busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[mem_addr] <= mem_data;
        end
        if (bottom_we)
        begin
            bottom_mem[mem_addr] <= mem_data;
        end
        if (rd_en)
        begin
            top_rd_reg    <= top_mem[rd_addr];
            bottom_rd_reg <= bottom_mem[rd_addr];
        end
    end

    assign top_rgb    = top_rd_reg;
    assign bottom_rgb = bottom_rd_reg;
    assign busy       = busy_reg;

endmodule

// ----- rtl/lpsd_scan_seq.sv -----
module lpsd_scan_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [lpsd_pkg::DWELL_W-1:0]      cfg_wr_data,
    input  logic                             tick,
    output lpsd_pkg::scan_event_t            ev,
    output logic [lpsd_pkg::HALF_ADDR_W-1:0]  rd_addr
);
    import lpsd_pkg::*;

    typedef enum logic [1:0] {
        PH_SHIFT = 2'd0,
        PH_LATCH = 2'd1,
        PH_LIT   = 2'd2
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [COL_W-1:0]   column_reg;
    logic [COL_W-1:0]   column_next;
    logic [LINE_W-1:0]  line_reg;
    logic [LINE_W-1:0]  line_next;
    logic [DWELL_W-1:0] dwell_count_reg;
    logic [DWELL_W-1:0] dwell_count_next;
    logic [DWELL_W-1:0] dwell_ticks_reg;
    logic [DWELL_W-1:0] dwell_ticks_next;

    logic [DWELL_W-1:0] count_inc;
    logic [DWELL_W-1:0] limit;
    logic               dwell_done;

    assign count_inc  = dwell_count_reg + 1'b1;
    assign limit      = (dwell_ticks_reg == '0) ? DWELL_W'(1) : dwell_ticks_reg;
    assign dwell_done = count_inc >= limit;

    always_comb
    begin
        ev.row   = ROW_ADDR_W'(line_reg);
        ev.shift = 1'b0;
        ev.latch = 1'b0;
        ev.off   = 1'b1;
        ev.fend  = 1'b0;

        phase_next       = phase_reg;
        column_next      = column_reg;
        line_next        = line_reg;
        dwell_count_next = dwell_count_reg;
        dwell_ticks_next = cfg_wr_en ? cfg_wr_data : dwell_ticks_reg;

        case (phase_reg)
            PH_LATCH:
            begin
                ev.latch = 1'b1;
                if (tick)
                begin
                    phase_next       = PH_LIT;
                    dwell_count_next = '0;
                end
            end
            PH_LIT:
            begin
                ev.off  = 1'b0;
                ev.fend = dwell_done && (line_reg == LINE_W'(LINE_PAIRS - 1));
                if (tick)
                begin
                    dwell_count_next = count_inc;
                    if (dwell_done)
                    begin
                        phase_next       = PH_SHIFT;
                        column_next      = '0;
                        line_next        = line_reg + 1'b1;
                        dwell_count_next = '0;
                    end
                end
            end
            default:
            begin
                ev.shift = 1'b1;
                if (tick)
                begin
                    phase_next  = PH_SHIFT;
                    column_next = column_reg + 1'b1;
                    if (column_reg == COL_W'(PANEL_WIDTH - 1))
                    begin
                        phase_next = PH_LATCH;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SHIFT;
            column_reg      <= '0;
            line_reg        <= '0;
            dwell_count_reg <= '0;
            dwell_ticks_reg <= DWELL_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            column_reg      <= column_next;
            line_reg        <= line_next;
            dwell_count_reg <= dwell_count_next;
            dwell_ticks_reg <= dwell_ticks_next;
        end
    end

    assign rd_addr = {line_reg, column_reg};

endmodule

// ----- rtl/led_panel_scan_driver_core.sv -----
// Scan driver for a 64x64 HUB75 panel with a 1-bit-per-channel frame store.
// One transaction per clock is accepted in steady state while out_stall is low,
// pixel writes and scan ticks alike, and each result passes through the s1
// stage register and then the output register; the rate is set by the single
// write port and registered read port of the frame store. After reset the frame
// store is cleared to black by a pass over the 2048 addresses of each half
// (both panel halves at once), during which in_stall is held high. The dwell
// register can be written at any time and takes effect on the next scan tick.
module led_panel_scan_driver_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lpsd_pkg::DWELL_W-1:0]     cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [lpsd_pkg::COORD_W-1:0]     pixel_x,
    input  logic [lpsd_pkg::COORD_W-1:0]     pixel_y,
    input  logic [lpsd_pkg::LEVEL_W-1:0]     red_level,
    input  logic [lpsd_pkg::LEVEL_W-1:0]     green_level,
    input  logic [lpsd_pkg::LEVEL_W-1:0]     blue_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lpsd_pkg::ROW_ADDR_W-1:0]  row_address,
    output logic                            top_red,
    output logic                            top_green,
    output logic                            top_blue,
    output logic                            bottom_red,
    output logic                            bottom_green,
    output logic                            bottom_blue,
    output logic                            shift_pulse,
    output logic                            latch_pulse,
    output logic                            output_off,
    output logic                            frame_end
);
    import lpsd_pkg::*;

    scan_event_t            ev;
    scan_event_t            item_ev;
    logic [HALF_ADDR_W-1:0] rd_addr;
    logic [HALF_ADDR_W-1:0] wr_addr;
    logic [RGB_W-1:0]       wr_rgb;
    logic [RGB_W-1:0]       top_rgb;
    logic [RGB_W-1:0]       bottom_rgb;
    logic                   busy;
    logic                   accept;
    logic                   is_tick;
    logic                   pixel_ok;
    logic                   s1_advance;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    scan_event_t            s1_ev_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    scan_event_t            out_ev_reg;
    logic [RGB_W-1:0]       out_top_reg;
    logic [RGB_W-1:0]       out_bottom_reg;

    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = busy || (s1_valid_reg && !s1_advance);
    assign accept     = in_valid && !in_stall;
    assign is_tick    = (operation == OP_SCAN_TICK);

    lpsd_scan_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick        (accept && is_tick),
        .ev          (ev),
        .rd_addr     (rd_addr)
    );

    assign pixel_ok = ({1'b0, pixel_x} < (COORD_W + 1)'(PANEL_WIDTH))
                   && ({1'b0, pixel_y} < (COORD_W + 1)'(PANEL_HEIGHT));
    assign wr_addr  = {pixel_y[LINE_W-1:0], pixel_x[COL_W-1:0]};
    assign wr_rgb   = {blue_level > LEVEL_THRESHOLD,
                       green_level > LEVEL_THRESHOLD,
                       red_level > LEVEL_THRESHOLD};

    lpsd_frame_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (accept && !is_tick && pixel_ok),
        .wr_bottom  (pixel_y[LINE_W]),
        .wr_addr    (wr_addr),
        .wr_data    (wr_rgb),
        .rd_en      (accept && is_tick && ev.shift),
        .rd_addr    (rd_addr),
        .top_rgb    (top_rgb),
        .bottom_rgb (bottom_rgb),
        .busy       (busy)
    );

    // A pixel write reports only the row and the held output enable level.
    always_comb
    begin
        item_ev = ev;
        if (!is_tick)
        begin
            item_ev.shift = 1'b0;
            item_ev.latch = 1'b0;
            item_ev.fend  = 1'b0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ev_reg <= item_ev;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_ev_reg     <= s1_ev_reg;
            out_top_reg    <= s1_ev_reg.shift ? top_rgb : '0;
            out_bottom_reg <= s1_ev_reg.shift ? bottom_rgb : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_address  = out_ev_reg.row;
    assign top_red      = out_top_reg[0];
    assign top_green    = out_top_reg[1];
    assign top_blue     = out_top_reg[2];
    assign bottom_red   = out_bottom_reg[0];
    assign bottom_green = out_bottom_reg[1];
    assign bottom_blue  = out_bottom_reg[2];
    assign shift_pulse  = out_ev_reg.shift;
    assign latch_pulse  = out_ev_reg.latch;
    assign output_off   = out_ev_reg.off;
    assign frame_end    = out_ev_reg.fend;

endmodule
